/* rtl/aes_cmac_block_core_assert.svh */
// Assertion macros shared by the CMAC engine RTL.
`ifndef AES_CMAC_BLOCK_CORE_ASSERT_SVH
`define AES_CMAC_BLOCK_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define AC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define AC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/acmac_pkg.sv */
// Types, register indexes and the AES S-box for the CMAC engine.
package acmac_pkg;

	typedef struct packed {
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic [4:0]  byte_count;
		logic        last;
	} acmac_in_t;

	typedef struct packed {
		logic [63:0] mac_hi;
		logic [63:0] mac_lo;
	} acmac_out_t;

	localparam logic CFG_KEY_HI = 1'b0;
	localparam logic CFG_KEY_LO = 1'b1;

	localparam logic [127:0] GF_POLY = 128'h87;
	localparam logic [7:0]   PAD_BYTE = 8'h80;
	localparam logic [4:0]   FULL_COUNT = 5'd16;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [0:9] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

endpackage

/* rtl/acmac_aes128.sv */
// Unrolled AES-128 encryption with on-the-fly key expansion.
module acmac_aes128 (
	input  logic [127:0] key,
	input  logic [127:0] blk,
	output logic [127:0] ct
);

	logic [127:0] rk [0:10];
	logic [127:0] st [0:10];

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, tw;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		tw = {acmac_pkg::SBOX[w3[23:16]] ^ rc, acmac_pkg::SBOX[w3[15:8]],
			acmac_pkg::SBOX[w3[7:0]], acmac_pkg::SBOX[w3[31:24]]};
		w0 = w0 ^ tw;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// Byte i of the state sits at bits 127-8i; row i%4, column i/4.
	function automatic logic [127:0] do_round(input logic [127:0] s, input logic final_rnd);
		logic [7:0] t [0:15];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[4*c+i] = acmac_pkg::SBOX[s[127-8*(4*((c+i)%4)+i) -: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			if (final_rnd) begin
				o[127-32*c -: 32] = {a0, a1, a2, a3};
			end else begin
				al = a0 ^ a1 ^ a2 ^ a3;
				o[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
					a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
			end
		end
		return o;
	endfunction

	assign rk[0] = key;
	assign st[0] = blk ^ key;

	for (genvar r = 1; r <= 10; r++) begin : g_round
		assign rk[r] = next_key(rk[r-1], acmac_pkg::RCON[r-1]);
		assign st[r] = do_round(st[r-1], (r == 10)) ^ rk[r];
	end

	assign ct = st[10];

endmodule

/* rtl/acmac_lastblk.sv */
// Last-block preparation: subkey doubling, 0x80 padding and subkey mix.
module acmac_lastblk (
	input  logic [127:0] l_val,
	input  logic         use_derived,
	input  logic [127:0] k1_reg,
	input  logic [127:0] k2_reg,
	input  logic [127:0] data,
	input  logic [4:0]   byte_count,
	input  logic         last,
	output logic [127:0] k1,
	output logic [127:0] k2,
	output logic [127:0] blk
);

	logic [127:0] k1_new, k2_new, padded;
	logic         full;

	function automatic logic [127:0] gf_dbl(input logic [127:0] x);
		return {x[126:0], 1'b0} ^ (x[127] ? acmac_pkg::GF_POLY : '0);
	endfunction

	assign k1_new = gf_dbl(l_val);
	assign k2_new = gf_dbl(k1_new);
	assign k1     = use_derived ? k1_new : k1_reg;
	assign k2     = use_derived ? k2_new : k2_reg;
	assign full   = (byte_count >= acmac_pkg::FULL_COUNT);

	always_comb begin
		padded = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < byte_count) begin
				padded[127-8*i -: 8] = data[127-8*i -: 8];
			end else if (5'(i) == byte_count) begin
				padded[127-8*i -: 8] = acmac_pkg::PAD_BYTE;
			end
		end
	end

	always_comb begin
		if (!last) begin
			blk = data;
		end else if (full) begin
			blk = data ^ k1;
		end else begin
			blk = padded ^ k2;
		end
	end

endmodule

/* rtl/aes_cmac_block_core.sv */
// Top level of the AES-128 CMAC engine: handshakes, chaining state, tag register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_stall  | in_data  (data_hi, data_lo, count, last)
//   out     | output    | out_valid / out_stall| out_data (mac_hi, mac_lo)
//   cfg     | input     | cfg_we               | cfg_idx, cfg_wdata (key_hi, key_lo)
//
// One block per cycle unless a held tag stalls a last block: a transaction lands in the
// input register, and in the next cycle both AES cores (subkey L = AES(key,0), then the
// chained block) run in one pass. A tag is written to out_data at the edge its last block
// leaves the input register, so it follows its block through the input and tag registers.
// Reset clears the key, the chain value and the message flag; no clearing pass.
// A held tag stalls only a last block; blocks that are not last keep flowing.
`include "aes_cmac_block_core_assert.svh"

module aes_cmac_block_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  acmac_pkg::acmac_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output acmac_pkg::acmac_out_t  out_data,
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [63:0]            cfg_wdata
);

	logic [63:0]           key_hi_q, key_lo_q;
	logic [127:0]          chain_q;
	logic [127:0]          k1_q, k2_q;
	logic                  in_msg_q;
	logic                  valid_s1;
	acmac_pkg::acmac_in_t  item_s1;
	logic                  out_valid_q;
	acmac_pkg::acmac_out_t out_q;

	logic [127:0] key, l_val, k1, k2, blk, ct;
	logic         advance;

	assign key = {key_hi_q, key_lo_q};

	// Advance the held block unless it is a last block and the tag slot is full and stalled.
	assign advance  = valid_s1 && (!item_s1.last || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Subkey source L: encrypt zero under the current key.
	acmac_aes128 u_aes_l (
		.key (key),
		.blk ('0),
		.ct  (l_val)
	);

	acmac_lastblk u_last (
		.l_val       (l_val),
		.use_derived (!in_msg_q),
		.k1_reg      (k1_q),
		.k2_reg      (k2_q),
		.data        ({item_s1.data_hi, item_s1.data_lo}),
		.byte_count  (item_s1.byte_count),
		.last        (item_s1.last),
		.k1          (k1),
		.k2          (k2),
		.blk         (blk)
	);

	// Chain step: encrypt the block mixed into the running chain value.
	acmac_aes128 u_aes_c (
		.key (key),
		.blk (chain_q ^ blk),
		.ct  (ct)
	);

	// Configuration: key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				acmac_pkg::CFG_KEY_HI: key_hi_q <= cfg_wdata;
				acmac_pkg::CFG_KEY_LO: key_lo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Control: input stage valid, chain state, tag valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			chain_q     <= '0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				if (item_s1.last) begin
					// Close the message: drop the chain, restart subkey derivation.
					chain_q  <= '0;
					in_msg_q <= 1'b0;
				end else begin
					chain_q  <= ct;
					in_msg_q <= 1'b1;
				end
			end
			if (advance && item_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: input item, subkeys, tag.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		// Hold subkeys derived at the first block of a message.
		if (advance && !in_msg_q) begin
			k1_q <= k1;
			k2_q <= k2;
		end
		if (advance && item_s1.last) begin
			out_q.mac_hi <= ct[127:64];
			out_q.mac_lo <= ct[63:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`AC_ASSERT_NXT(a_tag_follows_last, advance && item_s1.last, out_valid_q, "tag missing after last block")
	`AC_ASSERT_NXT(a_msg_open, advance && !item_s1.last, in_msg_q, "message not opened by block")
	`AC_ASSERT_NXT(a_msg_close, advance && item_s1.last, !in_msg_q && chain_q == '0, "chain not cleared after tag")
	`AC_ASSERT_IMP(a_idle_chain_zero, !in_msg_q, chain_q == '0, "chain nonzero outside a message")

endmodule

/* bench/aes_cmac_block_core_tb.sv */
// Self-checking testbench for the AES-128 CMAC block engine.
module aes_cmac_block_core_tb;

	typedef struct {
		logic [127:0] tag;
		bit           known_v;
		logic [127:0] known;
	} tag_expect_t;

	typedef struct {
		acmac_pkg::acmac_in_t blk;
		bit                   known_v;
		logic [127:0]         known;
	} msg_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	acmac_pkg::acmac_in_t  in_data;
	logic                  out_valid;
	logic                  out_stall;
	acmac_pkg::acmac_out_t out_data;
	logic                  cfg_we;
	logic                  cfg_idx;
	logic [63:0]           cfg_wdata;

	// literal tag riding along with the current transaction, if any
	bit           cur_known_v;
	logic [127:0] cur_known;

	// predictor state
	logic [127:0] key_m;
	logic [127:0] chain_m;
	logic [127:0] k1_m;
	logic [127:0] k2_m;
	bit           in_msg_m;

	tag_expect_t tag_expect_q[$];
	int          errors;
	int          burst_left;

	aes_cmac_block_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// AES-128 encryption, byte 0 in bits 127:120
	function automatic logic [127:0] aes_encrypt_128(input logic [127:0] key,
		input logic [127:0] blk);
		logic [7:0] rk [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] w [4];
		logic [7:0] tmp, a0, a1, a2, a3, all;
		logic [127:0] res;
		int i, r, c;
		for (i = 0; i < 16; i++) begin
			rk[i] = key[127 - 8 * i -: 8];
			s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
		end
		for (i = 16; i < 176; i += 4) begin
			for (c = 0; c < 4; c++) w[c] = rk[i - 4 + c];
			if (i % 16 == 0) begin
				tmp = w[0];
				w[0] = acmac_pkg::SBOX[w[1]] ^ acmac_pkg::RCON[i / 16 - 1];
				w[1] = acmac_pkg::SBOX[w[2]];
				w[2] = acmac_pkg::SBOX[w[3]];
				w[3] = acmac_pkg::SBOX[tmp];
			end
			for (c = 0; c < 4; c++) rk[i + c] = rk[i - 16 + c] ^ w[c];
		end
		for (r = 1; r <= 10; r++) begin
			for (c = 0; c < 4; c++)
				for (i = 0; i < 4; i++)
					t[4 * c + i] = acmac_pkg::SBOX[s[4 * ((c + i) % 4) + i]];
			for (c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				if (r != 10) begin
					all = a0 ^ a1 ^ a2 ^ a3;
					a0 = t[4 * c] ^ all ^ xtime(t[4 * c] ^ t[4 * c + 1]);
					a1 = t[4 * c + 1] ^ all ^ xtime(t[4 * c + 1] ^ t[4 * c + 2]);
					a2 = t[4 * c + 2] ^ all ^ xtime(t[4 * c + 2] ^ t[4 * c + 3]);
					a3 = t[4 * c + 3] ^ all ^ xtime(t[4 * c + 3] ^ t[4 * c]);
				end
				s[4 * c] = a0;
				s[4 * c + 1] = a1;
				s[4 * c + 2] = a2;
				s[4 * c + 3] = a3;
			end
			for (i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
		end
		for (i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ (v[127] ? acmac_pkg::GF_POLY : 128'h0);
	endfunction

	// Advance the predictor by one accepted block; queue a tag on a last block.
	task automatic cmac_predict(input acmac_pkg::acmac_in_t b, input bit kv,
		input logic [127:0] kval);
		logic [127:0] m;
		tag_expect_t e;
		int i;
		if (!in_msg_m) begin
			k1_m = gf_double(aes_encrypt_128(key_m, 128'h0));
			k2_m = gf_double(k1_m);
			chain_m = '0;
			in_msg_m = 1'b1;
		end
		m = {b.data_hi, b.data_lo};
		if (b.last) begin
			if (b.byte_count >= acmac_pkg::FULL_COUNT) begin
				m ^= k1_m;
			end else begin
				for (i = 0; i < 16; i++) begin
					if (i == b.byte_count) m[127 - 8 * i -: 8] = acmac_pkg::PAD_BYTE;
					else if (i > b.byte_count) m[127 - 8 * i -: 8] = 8'h00;
				end
				m ^= k2_m;
			end
		end
		chain_m = aes_encrypt_128(key_m, chain_m ^ m);
		if (b.last) begin
			e.tag = chain_m;
			e.known_v = kv;
			e.known = kval;
			tag_expect_q.push_back(e);
			chain_m = '0;
			in_msg_m = 1'b0;
		end
	endtask

	// Input side and config monitor: mirror every accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_idx == acmac_pkg::CFG_KEY_HI) key_m[127:64] = cfg_wdata;
				else key_m[63:0] = cfg_wdata;
			end
			if (in_valid && !in_stall) cmac_predict(in_data, cur_known_v, cur_known);
		end
	end

	// Output side: compare each delivered tag with the oldest expectation.
	always @(posedge clk) begin
		tag_expect_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tag_expect_q.size() == 0) begin
				$error("unexpected tag %h_%h", out_data.mac_hi, out_data.mac_lo);
				errors++;
			end else begin
				e = tag_expect_q.pop_front();
				if (out_data.mac_hi !== e.tag[127:64]) begin
					$error("mac_hi expected %h actual %h", e.tag[127:64], out_data.mac_hi);
					errors++;
				end
				if (out_data.mac_lo !== e.tag[63:0]) begin
					$error("mac_lo expected %h actual %h", e.tag[63:0], out_data.mac_lo);
					errors++;
				end
				if (e.known_v && {out_data.mac_hi, out_data.mac_lo} !== e.known) begin
					$error("mac expected %h actual %h", e.known,
						{out_data.mac_hi, out_data.mac_lo});
					errors++;
				end
			end
		end
	end

	// Receiver back-pressure: a pattern drawn at random from four modes, sometimes none at all.
	int stall_mode;
	int stall_cyc;
	always @(negedge clk) begin
		if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
		stall_cyc++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= (stall_cyc % 5 < 2);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Send one block; hold it until taken, then maybe open a gap between bursts.
	task automatic send_block(input acmac_pkg::acmac_in_t b, input bit kv,
		input logic [127:0] kval);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		cur_known_v <= kv;
		cur_known <= kval;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Drop valid, wait until every tag is out, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tag_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_key(input logic idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic acmac_pkg::acmac_in_t rand_block(input bit lst);
		acmac_pkg::acmac_in_t b;
		b.data_hi = {$urandom, $urandom};
		b.data_lo = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: b.byte_count = acmac_pkg::FULL_COUNT;
			1: b.byte_count = 5'd0;
			2: b.byte_count = 5'($urandom_range(17, 31));
			default: b.byte_count = 5'($urandom_range(0, 31));
		endcase
		b.last = lst;
		return b;
	endfunction

	localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

	msg_row_t dir_tab[] = '{
		// empty message, known answer
		'{'{64'h0, 64'h0, 5'd0, 1'b1}, 1, 128'hbb1d6929e95937287fa37d129b756746},
		// one full block, known answer
		'{'{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1}, 1,
			128'h070a16b46b4d4144f79bdd9dd04a287c},
		// 40-byte message, short last block, known answer
		'{'{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd0, 1'b0}, 0, 128'h0},
		'{'{64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd3, 1'b0}, 0, 128'h0},
		'{'{64'h30c81c46a35ce411, 64'h0, 5'd8, 1'b1}, 1,
			128'hdfa66747de9ae63030ca32611497c827},
		'{'{ONES, ONES, 5'd16, 1'b1}, 0, 128'h0},
		// count above sixteen saturates to a full block
		'{'{ONES, ONES, 5'd31, 1'b1}, 0, 128'h0},
		'{'{ONES, ONES, 5'd15, 1'b1}, 0, 128'h0},
		'{'{ONES, ONES, 5'd1, 1'b1}, 0, 128'h0},
		// bytes past the count are ignored
		'{'{ONES, ONES, 5'd0, 1'b1}, 0, 128'h0},
		'{'{64'h0, 64'h0, 5'd16, 1'b1}, 0, 128'h0},
		// non-last block with a count: taken as full
		'{'{ONES, 64'h0, 5'd0, 1'b0}, 0, 128'h0},
		'{'{64'h0, ONES, 5'd17, 1'b1}, 0, 128'h0}
	};

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		acmac_pkg::acmac_in_t b;
		int nblk, sent, ph, k;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = acmac_pkg::CFG_KEY_HI;
		cfg_wdata = '0;
		cur_known_v = 1'b0;
		cur_known = '0;
		key_m = '0;
		chain_m = '0;
		k1_m = '0;
		k2_m = '0;
		in_msg_m = 1'b0;
		errors = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_cyc = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: standard test key
		write_key(acmac_pkg::CFG_KEY_HI, 64'h2b7e151628aed2a6);
		write_key(acmac_pkg::CFG_KEY_LO, 64'habf7158809cf4f3c);
		foreach (dir_tab[i]) send_block(dir_tab[i].blk, dir_tab[i].known_v, dir_tab[i].known);
		drain();

		// random phases: extreme keys first, then random ones
		sent = 0;
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_key(acmac_pkg::CFG_KEY_HI, 64'h0);
					write_key(acmac_pkg::CFG_KEY_LO, 64'h0);
				end
				1: begin
					write_key(acmac_pkg::CFG_KEY_HI, ONES);
					write_key(acmac_pkg::CFG_KEY_LO, ONES);
				end
				default: begin
					// a phase may start mid-message: only one half changes sometimes
					if ($urandom_range(0, 3) != 0)
						write_key(acmac_pkg::CFG_KEY_HI, {$urandom, $urandom});
					write_key(acmac_pkg::CFG_KEY_LO, {$urandom, $urandom});
				end
			endcase
			k = 0;
			while (k < 50) begin
				nblk = $urandom_range(0, 4) == 0 ? $urandom_range(5, 9) : $urandom_range(1, 4);
				for (int j = 0; j < nblk; j++) begin
					b = rand_block(j == nblk - 1);
					send_block(b, 0, 128'h0);
					k++;
				end
			end
			// leave a message open so the next key write lands mid-message
			if (ph % 2 == 1) begin
				send_block(rand_block(1'b0), 0, 128'h0);
				k++;
			end
			sent += k;
			// hold off the sender until every tag is back
			drain();
		end
		send_block(rand_block(1'b1), 0, 128'h0);
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
